FILE: src/dctrv_pkg.sv
// ----------------------------------------------------------------------------
// dctrv_pkg
// Shared types, token codes and the value-token encoder of the coefficient
// run/value tokenizer.
// ----------------------------------------------------------------------------
package dctrv_pkg;

	// Field widths fixed by the token format.
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned CODE_W    = 5;
	localparam int unsigned EXTRA_W   = 10;
	localparam int unsigned RUN_CMP_W = 7;

	// Default block length in coefficients.
	localparam int unsigned BLOCK_COEFFS_DEF = 64;

	// Largest magnitude that is coded; larger ones are clamped.
	localparam logic [8:0] MAX_MAG = 9'd511;

	// Token codes, numbered densely.
	localparam logic [CODE_W-1:0] TOK_EOB       = 5'd0;
	localparam logic [CODE_W-1:0] TOK_SHORT_ZRL = 5'd1;
	localparam logic [CODE_W-1:0] TOK_ZRL       = 5'd2;
	localparam logic [CODE_W-1:0] TOK_PLUS_ONE  = 5'd3;
	localparam logic [CODE_W-1:0] TOK_PLUS_TWO  = 5'd5;
	localparam logic [CODE_W-1:0] TOK_LOW_VAL   = 5'd7;
	localparam logic [CODE_W-1:0] TOK_CAT3      = 5'd11;
	localparam logic [CODE_W-1:0] TOK_CAT8      = 5'd16;
	localparam logic [CODE_W-1:0] TOK_RUN1      = 5'd17;
	localparam logic [CODE_W-1:0] TOK_RUN1B     = 5'd22;
	localparam logic [CODE_W-1:0] TOK_RUN1C     = 5'd23;
	localparam logic [CODE_W-1:0] TOK_RUN2      = 5'd24;
	localparam logic [CODE_W-1:0] TOK_RUN2B     = 5'd25;
	localparam logic [CODE_W-1:0] TOK_LAST      = TOK_RUN2B;

	// One result beat.
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [EXTRA_W-1:0] extra;
		logic               present;
		logic               sat;
		logic               last;
	} dctrv_res_t;

	// Plain value token for a nonzero magnitude.
	function automatic dctrv_res_t value_tok(input logic [COEF_W-1:0] mag, input logic neg);
		dctrv_res_t r;
		logic [8:0] magc;
		logic [2:0] cat;
		logic [8:0] low;
		logic [EXTRA_W-1:0] sgn;
		r.code    = TOK_PLUS_ONE;
		r.extra   = '0;
		r.present = 1'b0;
		r.sat     = 1'b0;
		r.last    = 1'b1;
		if (mag > COEF_W'(MAX_MAG)) begin
			magc  = MAX_MAG;
			r.sat = 1'b1;
		end else begin
			magc = mag[8:0];
		end
		if      (magc <= 9'd8)  cat = 3'd0;
		else if (magc <= 9'd12) cat = 3'd1;
		else if (magc <= 9'd20) cat = 3'd2;
		else if (magc <= 9'd36) cat = 3'd3;
		else if (magc <= 9'd68) cat = 3'd4;
		else                    cat = 3'd5;
		case (cat)
			3'd0:    begin low = 9'd7;  sgn = 10'h002; end
			3'd1:    begin low = 9'd9;  sgn = 10'h004; end
			3'd2:    begin low = 9'd13; sgn = 10'h008; end
			3'd3:    begin low = 9'd21; sgn = 10'h010; end
			3'd4:    begin low = 9'd37; sgn = 10'h020; end
			default: begin low = 9'd69; sgn = 10'h200; end
		endcase
		if (mag == 16'd1) begin
			r.code = TOK_PLUS_ONE + CODE_W'(neg);
		end else if (mag == 16'd2) begin
			r.code = TOK_PLUS_TWO + CODE_W'(neg);
		end else if (mag <= 16'd6) begin
			r.code    = TOK_LOW_VAL + CODE_W'(mag[2:0] - 3'd3);
			r.extra   = EXTRA_W'(neg);
			r.present = 1'b1;
		end else begin
			r.code    = TOK_CAT3 + CODE_W'(cat);
			r.extra   = (neg ? sgn : '0) + EXTRA_W'(magc - low);
			r.present = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: src/dct_coefficient_run_value_tokenizer_core.sv
// ----------------------------------------------------------------------------
// dct_coefficient_run_value_tokenizer_core
// Turns quantized coefficients in scan order into run/value tokens.
// ----------------------------------------------------------------------------
// The block takes one coefficient beat per cycle and gives zero, one or two
// token beats for it. A zero inside a block gives no token and only extends
// the zero run; a zero that ends the block gives an end-of-block token. A
// nonzero value gives one token, or a zero-run token followed by a value
// token when the run is too long or the value too large for a combined
// token. The single result port sets the rate: an item giving two tokens
// holds the coefficient stage until both are sent. An accepted coefficient
// is held in the coefficient stage, its token in the result register,
// which drives the outputs. While the result register waits for the sink,
// the coefficient stage holds its beat and the input stalls, except for a
// zero that gives no token, which passes straight through. Magnitudes
// above 511 are clamped and flagged with saturated on the value token.
// ----------------------------------------------------------------------------
module dct_coefficient_run_value_tokenizer_core
	import dctrv_pkg::*;
#(
	parameter int unsigned BLOCK_COEFFS = BLOCK_COEFFS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COEF_W-1:0]   coefficient,
	input  logic                       block_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [CODE_W-1:0]          token_code,
	output logic [EXTRA_W-1:0]         extra_bits,
	output logic                       extra_present,
	output logic                       saturated,
	output logic                       last_of_run
);

	// The zero run never exceeds one less than the block length.
	localparam int unsigned RUN_W = $clog2(BLOCK_COEFFS);
	localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(BLOCK_COEFFS - 1);

	logic in_accept;

	// Zeros counted since the last nonzero value or block end.
	logic [RUN_W-1:0] zero_run_q;

	// Coefficient stage: the accepted beat with the run that precedes it.
	logic                valid_s1;
	logic [COEF_W-1:0]   coef_s1;
	logic                last_s1;
	logic [RUN_W-1:0]    run_s1;
	logic                phase_s1;

	// Result register.
	logic       out_valid_q;
	dctrv_res_t out_q;

	// Stage logic.
	logic                neg;
	logic [COEF_W-1:0]   mag;
	logic [RUN_CMP_W-1:0] run7;
	dctrv_res_t          val_tok;
	dctrv_res_t          res0;
	dctrv_res_t          res1;
	logic                no_res;
	logic                two_res;
	logic                out_free;
	logic                emit;
	logic                s1_done;

	assign in_accept = in_valid && in_ready;

	// The stage frees up once its final token moves into the result
	// register, or at once when the beat gives no token at all.
	assign out_free = !out_valid_q || out_ready;
	assign emit     = valid_s1 && !no_res && out_free;
	assign s1_done  = valid_s1 && (no_res || (out_free && (phase_s1 == two_res)));
	assign in_ready = !valid_s1 || s1_done;

	// Run bookkeeping happens as the beat is accepted, so the next beat
	// sees the updated count without waiting on the result side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= '0;
		end else if (in_accept) begin
			if (coefficient != '0 || block_last) begin
				zero_run_q <= '0;
			end else if (zero_run_q < RUN_MAX) begin
				zero_run_q <= zero_run_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (in_accept) begin
				phase_s1 <= 1'b0;
			end else if (emit && !phase_s1 && two_res) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			coef_s1 <= coefficient;
			last_s1 <= block_last;
			run_s1  <= zero_run_q;
		end
	end

	// Token selection for the beat in the coefficient stage.
	assign neg     = coef_s1[COEF_W-1];
	assign mag     = neg ? (~coef_s1 + 1'b1) : coef_s1;
	assign run7    = RUN_CMP_W'(run_s1);
	assign val_tok = value_tok(mag, neg);

	always_comb begin
		res0    = val_tok;
		res1    = val_tok;
		no_res  = 1'b0;
		two_res = 1'b0;
		if (mag == '0) begin
			res0 = '{code: TOK_EOB, extra: '0, present: 1'b0, sat: 1'b0, last: 1'b1};
			no_res = !last_s1;
		end else if (run7 == '0) begin
			res0 = val_tok;
		end else if (mag == 16'd1 && run7 <= 7'd17) begin
			res0.present = 1'b1;
			res0.sat     = 1'b0;
			if (run7 <= 7'd5) begin
				res0.code  = TOK_RUN1 + CODE_W'(run7 - 7'd1);
				res0.extra = EXTRA_W'(neg);
			end else if (run7 <= 7'd9) begin
				res0.code  = TOK_RUN1B;
				res0.extra = (neg ? 10'h004 : 10'h000) + EXTRA_W'(run7 - 7'd6);
			end else begin
				res0.code  = TOK_RUN1C;
				res0.extra = (neg ? 10'h008 : 10'h000) + EXTRA_W'(run7 - 7'd10);
			end
		end else if (mag <= 16'd3 && run7 <= 7'd3) begin
			res0.present = 1'b1;
			res0.sat     = 1'b0;
			if (run7 == 7'd1) begin
				res0.code  = TOK_RUN2;
				res0.extra = (neg ? 10'h002 : 10'h000) + EXTRA_W'(mag[1:0] - 2'd2);
			end else begin
				res0.code  = TOK_RUN2B;
				res0.extra = (neg ? 10'h004 : 10'h000)
					+ EXTRA_W'({mag[1:0] - 2'd2, 1'b0})
					+ EXTRA_W'(run7 - 7'd2);
			end
		end else begin
			// Run too long or value too large for a combined token.
			res0.code    = (run7 <= 7'd8) ? TOK_SHORT_ZRL : TOK_ZRL;
			res0.extra   = EXTRA_W'(run7 - 7'd1);
			res0.present = 1'b1;
			res0.sat     = 1'b0;
			res0.last    = 1'b0;
			res1         = val_tok;
			two_res      = 1'b1;
		end
	end

	// Result register: loads a token whenever it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= phase_s1 ? res1 : res0;
		end
	end

	assign out_valid     = out_valid_q;
	assign token_code    = out_q.code;
	assign extra_bits    = out_q.extra;
	assign extra_present = out_q.present;
	assign saturated     = out_q.sat;
	assign last_of_run   = out_q.last;

endmodule

FILE: src/dctrv_checker.sv
// ----------------------------------------------------------------------------
// dctrv_checker
// Port-level checks of the coefficient tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module dctrv_checker
	import dctrv_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CODE_W-1:0]  token_code,
	input logic [EXTRA_W-1:0] extra_bits,
	input logic               extra_present,
	input logic               saturated,
	input logic               last_of_run
);

	// A stalled result beat holds its code, extra bits and last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_code)
			&& $stable(extra_bits) && $stable(last_of_run))
		else $error("result beat changed while stalled");

	// A zero-run token always carries its run and is followed by a value.
	a_zrl_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_code == TOK_SHORT_ZRL || token_code == TOK_ZRL)
			|-> extra_present && !saturated && !last_of_run)
		else $error("malformed zero-run token");

	// Only a zero-run token leaves the item unfinished.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run
			|-> token_code == TOK_SHORT_ZRL || token_code == TOK_ZRL)
		else $error("unfinished item on a non zero-run token");

	// Clamping only happens in the top category.
	a_sat_cat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> token_code == TOK_CAT8 && extra_present)
		else $error("saturation outside the top category");

	// No extra bits without the flag, and no code past the last token.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_code <= TOK_LAST && (extra_present || extra_bits == '0))
		else $error("token code or extra bits out of range");

endmodule

bind dct_coefficient_run_value_tokenizer_core dctrv_checker u_dctrv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.token_code    (token_code),
	.extra_bits    (extra_bits),
	.extra_present (extra_present),
	.saturated     (saturated),
	.last_of_run   (last_of_run)
);
